>>> design/lru_kv_pkg.sv
// Package for the LRU key-value cache: sizes, field widths and operation codes.
`default_nettype none

package lru_kv_pkg;

  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int CAP_BITS   = 5;

  localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int COUNT_BITS = $clog2(ENTRIES + 1);

  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

endpackage

`default_nettype wire

>>> design/lru_key_value_cache_unit.sv
// Fully associative key-value cache with least-recently-used replacement.
//
// Input channel (in_valid/in_stall) carries one request beat: func (get or put), key
// and write_value. A beat is taken at a rising edge with in_valid high and in_stall low.
// Output channel (out_valid/out_stall) carries one result beat per request: hit,
// read_value, evicted and evicted_key.
// The request is registered on acceptance; once the output register can advance, the key
// is matched against all entries in parallel, the recency ranks, valid bits and entry
// contents are updated and the result is captured in the output register. Throughput is
// one request per cycle while out_stall is low, set by the combinational match and rank
// update over the entry table. When out_stall is high with a result waiting, the result
// register and the request register hold, and in_stall rises once the request register is
// occupied. capacity is written through cfg_wr_en/cfg_wr_data; the user must write it
// only while the block is idle; the block itself does not enforce this. It resets to 16.
// Capacity zero acts as one, values above the entry count as the entry count.
// Synchronous reset empties the cache (all entries invalid, live count zero) and drops
// any request or result in flight; entry keys and values are not cleared.
`default_nettype none

module lru_key_value_cache_unit
  import lru_kv_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CAP_BITS-1:0]   cfg_wr_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  func,
  input  wire logic [KEY_BITS-1:0]   key,
  input  wire logic [VALUE_BITS-1:0] write_value,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       hit,
  output logic [VALUE_BITS-1:0]      read_value,
  output logic                       evicted,
  output logic [KEY_BITS-1:0]        evicted_key
);

  logic [CAP_BITS-1:0]   capacity;

  // request register
  logic                  req_valid;
  logic                  req_func;
  logic [KEY_BITS-1:0]   req_key;
  logic [VALUE_BITS-1:0] req_value;

  // entry table
  logic [KEY_BITS-1:0]   entry_keys   [ENTRIES];
  logic [VALUE_BITS-1:0] entry_values [ENTRIES];
  logic [ENTRIES-1:0]    entry_valid;
  logic [IDX_BITS-1:0]   recency_rank [ENTRIES];
  logic [COUNT_BITS-1:0] live_count;

  logic [ENTRIES-1:0]    entry_valid_next;
  logic [IDX_BITS-1:0]   recency_rank_next [ENTRIES];
  logic [COUNT_BITS-1:0] live_count_next;

  logic                  advance;
  logic                  work;
  logic [ENTRIES-1:0]    match_vec;
  logic                  hit_now;
  logic [IDX_BITS-1:0]   hit_rank;
  logic [VALUE_BITS-1:0] hit_value;
  logic [COUNT_BITS-1:0] cap_eff;
  logic [IDX_BITS-1:0]   oldest_rank;
  logic [ENTRIES-1:0]    evict_vec;
  logic [ENTRIES-1:0]    free_vec;
  logic                  evict_now;
  logic                  insert_now;
  logic [ENTRIES-1:0]    ins_vec;
  logic [KEY_BITS-1:0]   evict_key_sel;

  assign advance  = !out_valid || !out_stall;
  assign work     = req_valid && advance;
  assign in_stall = req_valid && !advance;

  always_comb begin
    if (capacity == '0) begin
      cap_eff = COUNT_BITS'(1);
    end else if (int'(capacity) > ENTRIES) begin
      cap_eff = COUNT_BITS'(ENTRIES);
    end else begin
      cap_eff = COUNT_BITS'(capacity);
    end
  end

  // parallel match; live keys are unique, so the selects are one-hot
  always_comb begin
    oldest_rank   = IDX_BITS'(live_count - COUNT_BITS'(1));
    hit_rank      = '0;
    hit_value     = '0;
    evict_key_sel = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match_vec[i] = entry_valid[i] && (entry_keys[i] == req_key);
      evict_vec[i] = entry_valid[i] && (recency_rank[i] == oldest_rank);
      if (match_vec[i]) begin
        hit_rank  = hit_rank | recency_rank[i];
        hit_value = hit_value | entry_values[i];
      end
      if (evict_vec[i]) begin
        evict_key_sel = evict_key_sel | entry_keys[i];
      end
    end
  end

  assign hit_now    = |match_vec;
  // lowest invalid slot
  assign free_vec   = ~entry_valid & (entry_valid + ENTRIES'(1));
  assign evict_now  = !hit_now && (req_func == FUNC_PUT) && (live_count != '0) &&
                      (live_count >= cap_eff) && (|evict_vec);
  assign insert_now = !hit_now && (req_func == FUNC_PUT) && (evict_now || (|free_vec));
  assign ins_vec    = evict_now ? evict_vec : free_vec;

  always_comb begin
    entry_valid_next = entry_valid;
    live_count_next  = live_count;
    for (int i = 0; i < ENTRIES; i++) begin
      recency_rank_next[i] = recency_rank[i];
    end
    if (hit_now) begin
      // promote: newer live entries age by one
      for (int i = 0; i < ENTRIES; i++) begin
        if (match_vec[i]) begin
          recency_rank_next[i] = '0;
        end else if (entry_valid[i] && (recency_rank[i] < hit_rank)) begin
          recency_rank_next[i] = recency_rank[i] + IDX_BITS'(1);
        end
      end
    end else if (insert_now) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (ins_vec[i]) begin
          recency_rank_next[i] = '0;
          entry_valid_next[i]  = 1'b1;
        end else if (entry_valid[i]) begin
          recency_rank_next[i] = recency_rank[i] + IDX_BITS'(1);
        end
      end
      if (!evict_now) begin
        live_count_next = live_count + COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      req_valid <= 1'b1;
    end else if (advance) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_func  <= func;
      req_key   <= key;
      req_value <= write_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      live_count  <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        recency_rank[i] <= '0;
      end
    end else if (work) begin
      entry_valid <= entry_valid_next;
      live_count  <= live_count_next;
      for (int i = 0; i < ENTRIES; i++) begin
        recency_rank[i] <= recency_rank_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (work) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (hit_now && (req_func == FUNC_PUT) && match_vec[i]) begin
          entry_values[i] <= req_value;
        end else if (insert_now && ins_vec[i]) begin
          entry_keys[i]   <= req_key;
          entry_values[i] <= req_value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (work) begin
      hit         <= hit_now;
      read_value  <= (hit_now && (req_func == FUNC_GET)) ? hit_value : '0;
      evicted     <= evict_now;
      evicted_key <= evict_now ? evict_key_sel : '0;
    end
  end

  // live count tracks the valid bits
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(entry_valid) == int'(live_count))
    else $error("live count disagrees with valid bits");

  a_evict_keeps_count: assert property (@(posedge clk) disable iff (rst)
    work && evict_now |=> live_count == $past(live_count))
    else $error("eviction changed the live count");

  a_evict_not_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && evicted |-> !hit)
    else $error("result flags both hit and eviction");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (live_count == '0) && (entry_valid == '0) && !out_valid)
    else $error("reset left entries or results behind");

endmodule

`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for the LRU key-value cache: scoreboard class, drivers and top.

package lru_cache_check_pkg;
  import lru_kv_pkg::*;

  typedef struct packed {
    logic                  hit;
    logic [VALUE_BITS-1:0] read_value;
    logic                  evicted;
    logic [KEY_BITS-1:0]   evicted_key;
  } cache_reply_t;

  class cache_scoreboard;
    logic [KEY_BITS-1:0]   slot_key   [ENTRIES];
    logic [VALUE_BITS-1:0] slot_value [ENTRIES];
    bit                    slot_live  [ENTRIES];
    int unsigned           slot_age   [ENTRIES];
    int unsigned           live_entries;
    int unsigned           capacity;
    cache_reply_t          pending_replies [$];
    int unsigned           mismatches;
    int unsigned           requests;
    int unsigned           get_hits;
    int unsigned           put_hits;
    int unsigned           evictions;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        slot_key[i]   = '0;
        slot_value[i] = '0;
        slot_live[i]  = 1'b0;
        slot_age[i]   = 0;
      end
      live_entries = 0;
      capacity     = CAP_RESET;
      mismatches   = 0;
      requests     = 0;
      get_hits     = 0;
      put_hits     = 0;
      evictions    = 0;
    endfunction

    function void set_capacity(logic [CAP_BITS-1:0] value);
      capacity = value;
    endfunction

    // zero acts as one, anything above the table size saturates
    function int unsigned usable_slots();
      int unsigned c;
      c = capacity;
      if (c == 0) c = 1;
      if (c > ENTRIES) c = ENTRIES;
      return c;
    endfunction

    function void note_request(logic op, logic [KEY_BITS-1:0] k, logic [VALUE_BITS-1:0] wv);
      cache_reply_t r;
      int           found;
      int           victim;
      int unsigned  age;
      r      = '0;
      found  = -1;
      victim = -1;
      requests++;
      for (int i = 0; i < ENTRIES; i++)
        if (found < 0 && slot_live[i] && slot_key[i] == k) found = i;
      if (found >= 0) begin
        r.hit = 1'b1;
        if (op == FUNC_GET) begin
          r.read_value = slot_value[found];
          get_hits++;
        end else begin
          slot_value[found] = wv;
          put_hits++;
        end
        // promote: only entries newer than the hit one age
        age = slot_age[found];
        for (int i = 0; i < ENTRIES; i++)
          if (slot_live[i] && slot_age[i] < age) slot_age[i]++;
        slot_age[found] = 0;
      end else if (op == FUNC_PUT) begin
        if (live_entries >= usable_slots()) begin
          for (int i = 0; i < ENTRIES; i++)
            if (slot_live[i] && (victim < 0 || slot_age[i] > slot_age[victim])) victim = i;
          r.evicted     = 1'b1;
          r.evicted_key = slot_key[victim];
          slot_live[victim] = 1'b0;
          live_entries--;
          evictions++;
        end else begin
          for (int i = 0; i < ENTRIES; i++)
            if (victim < 0 && !slot_live[i]) victim = i;
        end
        for (int i = 0; i < ENTRIES; i++)
          if (slot_live[i]) slot_age[i]++;
        slot_key[victim]   = k;
        slot_value[victim] = wv;
        slot_live[victim]  = 1'b1;
        slot_age[victim]   = 0;
        live_entries++;
      end
      pending_replies.push_back(r);
    endfunction

    function void check_result(logic h, logic [VALUE_BITS-1:0] rv, logic e,
                               logic [KEY_BITS-1:0] ek);
      cache_reply_t want;
      if (pending_replies.size() == 0) begin
        $error("result beat with no request outstanding");
        mismatches++;
        return;
      end
      want = pending_replies.pop_front();
      if (h !== want.hit) begin
        $error("hit: expected %0d, got %0d", want.hit, h);
        mismatches++;
      end
      if (rv !== want.read_value) begin
        $error("read_value: expected %08h, got %08h", want.read_value, rv);
        mismatches++;
      end
      if (e !== want.evicted) begin
        $error("evicted: expected %0d, got %0d", want.evicted, e);
        mismatches++;
      end
      if (ek !== want.evicted_key) begin
        $error("evicted_key: expected %08h, got %08h", want.evicted_key, ek);
        mismatches++;
      end
    endfunction

    function void flag_leftovers();
      if (pending_replies.size() != 0) begin
        $error("%0d result beats never arrived", pending_replies.size());
        mismatches += pending_replies.size();
      end
    endfunction
  endclass

endpackage

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lru_kv_pkg::*;
  import lru_cache_check_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned LONG_HOLD     = 40;
  localparam int unsigned PHASE_ITEMS   = 190;
  localparam int unsigned POOL_MAX      = 48;
  localparam int unsigned RANDOM_PHASES = 8;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CAP_BITS-1:0]   cfg_wr_data;
  logic                  in_valid;
  logic                  in_stall;
  logic                  func;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] write_value;
  logic                  out_valid;
  logic                  out_stall;
  logic                  hit;
  logic [VALUE_BITS-1:0] read_value;
  logic                  evicted;
  logic [KEY_BITS-1:0]   evicted_key;

  cache_scoreboard board;
  int unsigned     cycles = 0;
  int unsigned     send_gap_pct;
  int unsigned     recv_hold_pct;
  int unsigned     hold_seq;
  int unsigned     hold_seen = 0;
  int unsigned     hold_left = 0;
  int unsigned     phase_caps [RANDOM_PHASES];
  logic [KEY_BITS-1:0] key_pool [POOL_MAX];
  int unsigned     pool_size = 0;

  lru_key_value_cache_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .key         (key),
    .write_value (write_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit),
    .read_value  (read_value),
    .evicted     (evicted),
    .evicted_key (evicted_key)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) cycles <= cycles + 1;

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_wr_en) board.set_capacity(cfg_wr_data);
      if (in_valid && !in_stall) board.note_request(func, key, write_value);
      if (out_valid === 1'b1 && !out_stall)
        board.check_result(hit, read_value, evicted, evicted_key);
    end
  end

  // receiver: random stalls, or a long hold when one is requested
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_hold_pct);
    end
  end

  task automatic send_request(input logic op, input logic [KEY_BITS-1:0] k,
                              input logic [VALUE_BITS-1:0] wv);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    func        <= op;
    key         <= k;
    write_value <= wv;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_until_drained(input int unsigned settle);
    in_valid <= 1'b0;
    while (board.pending_replies.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_capacity(input int unsigned value);
    cfg_wr_data <= CAP_BITS'(value);
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // keep most of the old keys so that live entries keep hitting
  task automatic refresh_pool();
    int unsigned want;
    want = board.usable_slots();
    if (board.live_entries > want) want = board.live_entries;
    want = want + want / 2 + 1;
    if (want > POOL_MAX) want = POOL_MAX;
    for (int i = 0; i < POOL_MAX; i++)
      if (i >= pool_size || $urandom_range(3) == 0) key_pool[i] = $urandom;
    pool_size = want;
  endtask

  function automatic logic [KEY_BITS-1:0] pick_key();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 8) return $urandom;
    if (roll < 14)
      return key_pool[$urandom_range(pool_size - 1)] ^ (1 << $urandom_range(KEY_BITS - 1));
    return key_pool[$urandom_range(pool_size - 1)];
  endfunction

  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic op;
    board         = new();
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_valid      = 1'b0;
    func          = FUNC_GET;
    key           = '0;
    write_value   = '0;
    out_stall     = 1'b0;
    send_gap_pct  = 6;
    recv_hold_pct = 84;
    hold_seq      = 0;
    phase_caps    = '{1, 3, 7, 12, 16, 31, 2, 20};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty cache at reset capacity: every field zero, get ignores write_value
    send_request(FUNC_GET, '0, '0);
    send_request(FUNC_GET, '1, '1);
    wait_until_drained(4);

    // capacity zero keeps one entry
    write_capacity(0);
    send_request(FUNC_PUT, '0, '1);
    send_request(FUNC_GET, '0, '0);
    send_request(FUNC_PUT, '1, '0);
    send_request(FUNC_GET, '0, '1);
    send_request(FUNC_GET, '1, '0);
    send_request(FUNC_PUT, '1, 32'ha5a5_a5a5);
    send_request(FUNC_GET, '1, '0);
    send_request(FUNC_PUT, '0, '0);
    send_request(FUNC_GET, '0, '1);
    wait_until_drained(4);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 2) begin
        send_gap_pct  <= 84;
        recv_hold_pct <= 6;
      end else if (ph == 5) begin
        send_gap_pct  <= 0;
        recv_hold_pct <= 0;
      end
      write_capacity(phase_caps[ph]);
      @(negedge clk);
      refresh_pool();
      // back-pressure: hold the output long enough to stall the input
      if (ph == RANDOM_PHASES - 1) hold_seq <= hold_seq + 1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        op = ($urandom_range(99) < 45) ? FUNC_PUT : FUNC_GET;
        send_request(op, pick_key(), $urandom);
      end
      wait_until_drained(4);
    end

    wait_until_drained(8);
    board.flag_leftovers();
    $display("Ran %0d requests over %0d capacity settings and three idling mixes,",
             board.requests, RANDOM_PHASES + 2);
    $display("with %0d get hits, %0d put hits and %0d evictions checked.",
             board.get_hits, board.put_hits, board.evictions);
    if (board.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
